@@ sv/psf_pkg.sv @@
package psf_pkg;

   localparam int FIELD_COUNT = 8;
   localparam int OBJ_IN_W    = 32;
   localparam int CFG_W       = 4;
   localparam int IDX_OUT_W   = 6;
   localparam int STR_W       = 6;
   localparam int FIT_W       = 12;

   localparam logic [CFG_W-1:0] DIMS_RESET = 4'd2;
   localparam logic [STR_W-1:0] STR_MAX    = 6'd63;
   localparam logic [FIT_W-1:0] FIT_MAX    = 12'd4095;

   // result buffer between the merge stage and the response channel
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // flags that travel with one compared pair down the pipe
   typedef struct packed {
      logic valid;
      logic pass2;
      logic first;
      logic last;
      logic last_row;
      logic self_pair;
   } tag_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] individual_index;
      logic [STR_W-1:0]     strength;
      logic [FIT_W-1:0]     raw_fitness;
      logic                 nondominated;
      logic                 overflowed;
      logic                 last_result;
   } rsp_type;

endpackage

@@ sv/psf_if.sv @@
interface psf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] obj_0;
   logic [31:0] obj_1;
   logic [31:0] obj_2;
   logic [31:0] obj_3;
   logic [31:0] obj_4;
   logic [31:0] obj_5;
   logic [31:0] obj_6;
   logic [31:0] obj_7;
   logic        last_individual;

   modport source (
      output valid, obj_0, obj_1, obj_2, obj_3, obj_4, obj_5, obj_6, obj_7,
             last_individual,
      input  ready
   );
   modport sink (
      input  valid, obj_0, obj_1, obj_2, obj_3, obj_4, obj_5, obj_6, obj_7,
             last_individual,
      output ready
   );
endinterface

interface psf_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  individual_index;
   logic [5:0]  strength;
   logic [11:0] raw_fitness;
   logic        nondominated;
   logic        overflowed;
   logic        last_result;

   modport source (
      output valid, individual_index, strength, raw_fitness, nondominated,
             overflowed, last_result,
      input  ready
   );
   modport sink (
      input  valid, individual_index, strength, raw_fitness, nondominated,
             overflowed, last_result,
      output ready
   );
endinterface

interface psf_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] objectives_in_use;

   modport source (
      output valid, objectives_in_use,
      input  ready
   );
   modport sink (
      input  valid, objectives_in_use,
      output ready
   );
endinterface

@@ sv/psf_lane.sv @@
module psf_lane #(
   parameter int MAX_POP  = 64,
   parameter int OBJ_BITS = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(MAX_POP)-1:0] wr_addr,
   input  logic [OBJ_BITS-1:0]        wr_data,
   input  logic [$clog2(MAX_POP)-1:0] rd_addr_a,
   input  logic [$clog2(MAX_POP)-1:0] rd_addr_b,
   output logic                       gt_ff,
   output logic                       ne_ff
);

   logic [OBJ_BITS-1:0] mem [MAX_POP];
   logic [OBJ_BITS-1:0] a_ff;
   logic [OBJ_BITS-1:0] b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      a_ff <= mem[rd_addr_a];
      b_ff <= mem[rd_addr_b];
   end

   // a is the candidate dominator, b the candidate dominated
   always_ff @(posedge clock) begin
      gt_ff <= a_ff > b_ff;
      ne_ff <= a_ff != b_ff;
   end

endmodule

@@ sv/psf_merge.sv @@
module psf_merge #(
   parameter int MAX_POP = 64,
   parameter int MAX_DIM = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  psf_pkg::tag_type           tag0,
   input  logic [$clog2(MAX_POP)-1:0] row0,
   input  logic [$clog2(MAX_POP)-1:0] col0,
   input  logic [MAX_DIM-1:0]         gt,
   input  logic [MAX_DIM-1:0]         ne,
   input  logic [MAX_DIM-1:0]         mask,
   input  logic                       ovf,
   output logic                       res_valid,
   output psf_pkg::rsp_type           res
);

   localparam int IDX_W = $clog2(MAX_POP);

   logic [psf_pkg::STR_W-1:0] str_mem [MAX_POP];
   logic [psf_pkg::STR_W-1:0] str_rd_ff;
   logic [psf_pkg::STR_W-1:0] str_d2_ff;

   psf_pkg::tag_type tag1_ff, tag2_ff;
   logic [IDX_W-1:0] row1_ff, row2_ff;

   logic [psf_pkg::STR_W-1:0] cnt_ff, cnt_in, cnt_base;
   logic [psf_pkg::FIT_W-1:0] sum_ff, sum_in, sum_base;
   logic [psf_pkg::FIT_W:0]   sum_wide;
   logic [psf_pkg::STR_W-1:0] own_ff, own_in;
   logic                      beats;
   logic                      str_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      row1_ff   <= row0;
      row2_ff   <= row1_ff;
      str_rd_ff <= str_mem[col0];
      str_d2_ff <= str_rd_ff;
      if (str_we) begin
         str_mem[row2_ff] <= cnt_in;
      end
   end

   always_comb begin
      beats    = ~|(gt & mask) & |(ne & mask);
      cnt_base = tag2_ff.first ? '0 : cnt_ff;
      cnt_in   = (beats && cnt_base != psf_pkg::STR_MAX) ? cnt_base + 1'b1 : cnt_base;
      sum_base = tag2_ff.first ? '0 : sum_ff;
      sum_wide = {1'b0, sum_base}
               + (beats ? {{(psf_pkg::FIT_W + 1 - psf_pkg::STR_W){1'b0}}, str_d2_ff}
                        : '0);
      // saturate on carry out
      sum_in   = sum_wide[psf_pkg::FIT_W] ? psf_pkg::FIT_MAX
                                          : sum_wide[psf_pkg::FIT_W-1:0];
      own_in   = tag2_ff.self_pair ? str_d2_ff : own_ff;
      str_we   = tag2_ff.valid && !tag2_ff.pass2 && tag2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         if (tag2_ff.pass2) begin
            sum_ff <= sum_in;
            own_ff <= own_in;
         end else begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_comb begin
      res_valid            = tag2_ff.valid && tag2_ff.pass2 && tag2_ff.last;
      res.individual_index = psf_pkg::IDX_OUT_W'(row2_ff);
      res.strength         = own_in;
      res.raw_fitness      = sum_in;
      res.nondominated     = sum_in == '0;
      res.overflowed       = ovf;
      res.last_result      = tag2_ff.last_row;
   end

endmodule

@@ sv/psf_fifo.sv @@
module psf_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  psf_pkg::rsp_type              push_word,
   input  logic                          pop,
   output logic                          out_valid,
   output psf_pkg::rsp_type              out_word,
   output logic [psf_pkg::FIFO_CNT_W-1:0] count
);

   psf_pkg::rsp_type                 slot_ff [psf_pkg::FIFO_DEPTH];
   logic [psf_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [psf_pkg::FIFO_CNT_W-1:0]   cnt_ff;
   logic                             do_pop;

   assign out_valid = cnt_ff != '0;
   assign out_word  = slot_ff[rd_ptr_ff];
   assign count     = cnt_ff;
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

@@ sv/pareto_strength_fitness.sv @@
// Pareto strength and raw fitness over a loaded population, all objectives minimized.
// req_if: one word per individual (objective values and a last flag), one word per cycle
//   while loading. Words past MAX_POP are dropped and mark the run as overflowed.
// csr_if: objective count, always ready; it is to be written only while the block is
//   idle, which the user must ensure, as the block does not enforce it.
// rsp_if: after the last word, one result per stored individual, in load order.
// Each lane holds one objective of every individual in a two-read-port memory, so one
// ordered pair (a, b) is compared per cycle. Strength takes one pass of N*N pairs, raw
// fitness a second pass of N*N pairs, N the number stored; a gap state separates them.
// Loading resumes after a flush state that follows the last issued pair, while results
// still drain.
// A 4-word result buffer sits in front of rsp_if; when the receiver stalls and it fills,
// the second pass pauses at the end of a row and continues once words are taken.
// Reset empties the population, clears the overflow mark and sets the objective count to 2.
module pareto_strength_fitness #(
   parameter int MAX_POP  = 64,
   parameter int MAX_DIM  = 8,
   parameter int OBJ_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   psf_req_if.sink      req_if,
   psf_rsp_if.source    rsp_if,
   psf_csr_if.sink      csr_if
);

   localparam int IDX_W = $clog2(MAX_POP);
   localparam int CNT_W = $clog2(MAX_POP + 1);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_P1    = 5'b00010,
      ST_GAP   = 5'b00100,
      ST_P2    = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [psf_pkg::CFG_W-1:0] dims_cfg_ff;
   logic [psf_pkg::CFG_W-1:0] dims_eff;
   logic [MAX_DIM-1:0]        mask_cur;
   logic [MAX_DIM-1:0]        mask_ff, mask_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] n_run_ff, n_run_in;
   logic             ovf_run_ff, ovf_run_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             wait_ff, wait_in;
   logic [psf_pkg::FIFO_CNT_W-1:0] pend_ff, pend_in;

   logic                             req_accept, store;
   logic [psf_pkg::OBJ_IN_W-1:0]     obj [psf_pkg::FIELD_COUNT];
   logic                             last_j, last_i, issue, reserve;
   logic [IDX_W-1:0]                 addr_a, addr_b;
   psf_pkg::tag_type                 tag0;
   logic [MAX_DIM-1:0]               gt, ne;
   logic                             res_valid;
   psf_pkg::rsp_type                 res, out_word;
   logic                             rsp_accept;
   logic [psf_pkg::FIFO_CNT_W-1:0]   fifo_count;

   assign obj[0] = req_if.obj_0;
   assign obj[1] = req_if.obj_1;
   assign obj[2] = req_if.obj_2;
   assign obj[3] = req_if.obj_3;
   assign obj[4] = req_if.obj_4;
   assign obj[5] = req_if.obj_5;
   assign obj[6] = req_if.obj_6;
   assign obj[7] = req_if.obj_7;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = state_ff == ST_LOAD;
   assign req_accept   = req_if.valid && req_if.ready;
   assign store        = req_accept && (count_ff < CNT_W'(MAX_POP));
   assign rsp_accept   = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_cfg_ff <= psf_pkg::DIMS_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         dims_cfg_ff <= csr_if.objectives_in_use;
      end
   end

   // zero counts as one, anything past the lane count as all lanes
   always_comb begin
      if (dims_cfg_ff == '0) begin
         dims_eff = psf_pkg::CFG_W'(1);
      end else if (dims_cfg_ff > psf_pkg::CFG_W'(MAX_DIM)) begin
         dims_eff = psf_pkg::CFG_W'(MAX_DIM);
      end else begin
         dims_eff = dims_cfg_ff;
      end
      for (int d = 0; d < MAX_DIM; d++) begin
         mask_cur[d] = psf_pkg::CFG_W'(d) < dims_eff;
      end
   end

   assign last_j = (CNT_W'(j_ff) + CNT_W'(1)) == n_run_ff;
   assign last_i = (CNT_W'(i_ff) + CNT_W'(1)) == n_run_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      n_run_in   = n_run_ff;
      ovf_run_in = ovf_run_ff;
      mask_in    = mask_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      wait_in    = wait_ff;
      issue      = 1'b0;
      reserve    = 1'b0;
      addr_a     = i_ff;
      addr_b     = j_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               count_in = store ? count_ff + 1'b1 : count_ff;
               ovf_in   = ovf_ff | !store;
               if (req_if.last_individual) begin
                  n_run_in   = store ? count_ff + 1'b1 : count_ff;
                  ovf_run_in = ovf_ff | !store;
                  mask_in    = mask_cur;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  i_in       = '0;
                  j_in       = '0;
                  state_in   = ST_P1;
               end
            end
         end
         ST_P1: begin
            issue = 1'b1;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in     = '0;
                  wait_in  = 1'b0;
                  state_in = ST_GAP;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_GAP: begin
            // lets the last strength write land before the second pass reads it
            wait_in = 1'b1;
            if (wait_ff) begin
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            addr_a = j_ff;
            addr_b = i_ff;
            if (!last_j) begin
               issue = 1'b1;
               j_in  = j_ff + 1'b1;
            end else if (pend_ff < psf_pkg::FIFO_CNT_W'(psf_pkg::FIFO_DEPTH)) begin
               issue   = 1'b1;
               reserve = 1'b1;
               j_in    = '0;
               if (last_i) begin
                  i_in     = '0;
                  wait_in  = 1'b0;
                  state_in = ST_FLUSH;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            wait_in = 1'b1;
            if (wait_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      unique case ({reserve, rsp_accept})
         2'b10:   pend_in = pend_ff + 1'b1;
         2'b01:   pend_in = pend_ff - 1'b1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         n_run_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         wait_ff  <= 1'b0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         n_run_ff <= n_run_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         wait_ff  <= wait_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_run_ff <= ovf_run_in;
      mask_ff    <= mask_in;
   end

   always_comb begin
      tag0.valid     = issue;
      tag0.pass2     = state_ff == ST_P2;
      tag0.first     = j_ff == '0;
      tag0.last      = last_j;
      tag0.last_row  = last_i;
      tag0.self_pair = i_ff == j_ff;
   end

   for (genvar d = 0; d < MAX_DIM; d++) begin : g_lane
      psf_lane #(
         .MAX_POP  (MAX_POP),
         .OBJ_BITS (OBJ_BITS)
      ) u_lane (
         .clock     (clock),
         .wr_en     (store),
         .wr_addr   (count_ff[IDX_W-1:0]),
         .wr_data   (OBJ_BITS'(obj[d])),
         .rd_addr_a (addr_a),
         .rd_addr_b (addr_b),
         .gt_ff     (gt[d]),
         .ne_ff     (ne[d])
      );
   end

   psf_merge #(
      .MAX_POP (MAX_POP),
      .MAX_DIM (MAX_DIM)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .tag0      (tag0),
      .row0      (i_ff),
      .col0      (j_ff),
      .gt        (gt),
      .ne        (ne),
      .mask      (mask_ff),
      .ovf       (ovf_run_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   psf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res),
      .pop       (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_word  (out_word),
      .count     (fifo_count)
   );

   assign rsp_if.individual_index = out_word.individual_index;
   assign rsp_if.strength         = out_word.strength;
   assign rsp_if.raw_fitness      = out_word.raw_fitness;
   assign rsp_if.nondominated     = out_word.nondominated;
   assign rsp_if.overflowed       = out_word.overflowed;
   assign rsp_if.last_result      = out_word.last_result;

   // the reservation count must cover every word buffered or in flight
   a_pend_covers_fifo: assert property (@(posedge clock) disable iff (reset)
      pend_ff >= fifo_count && pend_ff <= psf_pkg::FIFO_CNT_W'(psf_pkg::FIFO_DEPTH))
      else $error("result reservations lost track of the buffer");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> fifo_count != psf_pkg::FIFO_CNT_W'(psf_pkg::FIFO_DEPTH))
      else $error("result pushed into a full buffer");

   a_last_word_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.last_individual) |=> (state_ff == ST_P1 && n_run_ff != '0))
      else $error("last word did not start a nonempty run");

endmodule
